// File: hw/rtl/aaid_pkg.sv
// Package with shared types and constants for the area-average downscaler.
`timescale 1ns / 1ps

package aaid_pkg;

  // Fixed widths and limits of the configuration port, size registers, rows and component lanes
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned CFG_DW     = 17;
  localparam int unsigned CFG_IW     = 3;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned LANES      = 3;
  localparam int unsigned LANE_W     = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_SRC_WIDTH    = 3'd0,
    CFG_SRC_HEIGHT   = 3'd1,
    CFG_DST_WIDTH    = 3'd2,
    CFG_DST_HEIGHT   = 3'd3,
    CFG_SCALE_WEIGHT = 3'd4,
    CFG_COLOR_MODE   = 3'd5
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HORIZ,
    ST_VERT,
    ST_FINISH
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic              clear;
    logic              load;
    logic              horiz;
    logic              vert;
    logic [LANE_W-1:0] lane;
    logic              finish;
  } aaid_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic need_vert;
    logic emit;
    logic out_busy;
  } aaid_status_t;

endpackage

// File: hw/rtl/aaid_ctrl.sv
// Controller state machine sequencing one source pixel through the datapath.
`timescale 1ns / 1ps

module aaid_ctrl import aaid_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  aaid_status_t status_i,
  output aaid_cmd_t    cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [LANE_W-1:0] lane_q, lane_d;

  // State and lane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    lane_d     = lane_q;
    cmd_o      = '0;
    cmd_o.lane = lane_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HORIZ;
        end
      end
      ST_HORIZ: begin
        cmd_o.horiz = 1'b1;
        lane_d      = '0;
        state_d     = status_i.need_vert ? ST_VERT : ST_FINISH;
      end
      ST_VERT: begin
        cmd_o.vert = 1'b1;
        if (lane_q == LANE_W'(LANES - 1)) begin
          state_d = ST_FINISH;
        end else begin
          lane_d = lane_q + LANE_W'(1);
        end
      end
      ST_FINISH: begin
        // Hold while a result is due and the output register is still full
        if (!(status_i.need_vert && status_i.emit && status_i.out_busy)) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/aaid_datapath.sv
// Datapath: config registers, spans, counters, line accumulator memory and output register.
`timescale 1ns / 1ps

module aaid_datapath import aaid_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic [7:0]        comp_a_i,
  input  logic [7:0]        comp_b_i,
  input  logic [7:0]        comp_c_i,
  input  aaid_cmd_t         cmd_i,
  output aaid_status_t      status_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        out_a_o,
  output logic [7:0]        out_b_o,
  output logic [7:0]        out_c_o,
  output logic              row_end_o,
  output logic              frame_end_o
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned WW   = WEIGHT_BITS + 1;
  localparam int unsigned SUMW = 8 + WEIGHT_BITS;
  localparam int unsigned ACCW = 8 + 2 * WEIGHT_BITS;
  localparam int unsigned PW   = SUMW + WW;
  localparam logic [WW-1:0] WONE = WW'(1) << WEIGHT_BITS;

  // Configuration registers
  logic [SIZE_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [CFG_DW-1:0] scale_weight_q;
  logic              color_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= SIZE_W'(640);
      src_height_q   <= SIZE_W'(480);
      dst_width_q    <= SIZE_W'(320);
      dst_height_q   <= SIZE_W'(240);
      scale_weight_q <= CFG_DW'(32768);
      color_mode_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:    src_width_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_SRC_HEIGHT:   src_height_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_DST_WIDTH:    dst_width_q    <= cfg_data_i[SIZE_W-1:0];
        CFG_DST_HEIGHT:   dst_height_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_SCALE_WEIGHT: scale_weight_q <= cfg_data_i;
        CFG_COLOR_MODE:   color_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp registers to their working ranges
  logic [CW-1:0]    sw, dw;
  logic [ROW_W-1:0] sh, dh;
  logic [WW-1:0]    w;

  always_comb begin
    if (src_width_q == '0) sw = CW'(1);
    else if (32'(src_width_q) > 32'(MAX_WIDTH)) sw = CW'(MAX_WIDTH);
    else sw = CW'(src_width_q);
    if (dst_width_q == '0) dw = CW'(1);
    else if (32'(dst_width_q) > 32'(MAX_WIDTH)) dw = CW'(MAX_WIDTH);
    else dw = CW'(dst_width_q);
    if (src_height_q == '0) sh = ROW_W'(1);
    else if (32'(src_height_q) > 32'(MAX_HEIGHT)) sh = ROW_W'(MAX_HEIGHT);
    else sh = ROW_W'(src_height_q);
    if (dst_height_q == '0) dh = ROW_W'(1);
    else if (32'(dst_height_q) > 32'(MAX_HEIGHT)) dh = ROW_W'(MAX_HEIGHT);
    else dh = ROW_W'(dst_height_q);
    if (scale_weight_q == '0) w = WW'(1);
    else if (32'(scale_weight_q) > 32'(WONE)) w = WONE;
    else w = WW'(scale_weight_q);
  end

  // Stream state
  logic [CW-1:0]    src_col_q, dst_col_q;
  logic [ROW_W-1:0] src_row_q, dst_row_q;
  logic [WW-1:0]    x_span_q, y_span_q;
  logic [SUMW-1:0]  col_part_q [LANES];

  // Per-pixel decisions, taken when the pixel is loaded
  logic            last_col, last_row, col_close, row_close, need_vert, emit, re, fe;
  logic [WW-1:0]   h_cur, h_rem, v_cur, v_rem;

  always_comb begin
    last_col  = ((CW+1)'(src_col_q) + (CW+1)'(1)) >= (CW+1)'(sw);
    last_row  = ((ROW_W+1)'(src_row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(sh);
    col_close = (w >= x_span_q) || last_col;
    row_close = (w >= y_span_q) || last_row;
    h_cur     = (w < x_span_q) ? w : x_span_q;
    h_rem     = ((w > x_span_q) && !last_col) ? w - x_span_q : '0;
    v_cur     = (w < y_span_q) ? w : y_span_q;
    v_rem     = ((w > y_span_q) && !last_row) ? w - y_span_q : '0;
    need_vert = col_close && (dst_col_q < dw);
    emit      = row_close && (dst_row_q < dh);
    re        = ((CW+1)'(dst_col_q) + (CW+1)'(1) == (CW+1)'(dw)) || last_col;
    fe        = re && (((ROW_W+1)'(dst_row_q) + (ROW_W+1)'(1) == (ROW_W+1)'(dh))
                       || last_row);
  end

  logic            lc_q, lr_q, cc_q, rc_q, nv_q, em_q, re_q, fe_q;
  logic [WW-1:0]   h_cur_q, h_rem_q, v_cur_q, v_rem_q, w_q;
  logic [7:0]      pix_q [LANES];

  // Latch the pixel and its decisions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= 1'b0;
      lr_q <= 1'b0;
      cc_q <= 1'b0;
      rc_q <= 1'b0;
      nv_q <= 1'b0;
      em_q <= 1'b0;
      re_q <= 1'b0;
      fe_q <= 1'b0;
    end else if (cmd_i.load) begin
      lc_q <= last_col;
      lr_q <= last_row;
      cc_q <= col_close;
      rc_q <= row_close;
      nv_q <= need_vert;
      em_q <= emit;
      re_q <= re;
      fe_q <= fe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_cur_q  <= h_cur;
      h_rem_q  <= h_rem;
      v_cur_q  <= v_cur;
      v_rem_q  <= v_rem;
      w_q      <= w;
      pix_q[0] <= comp_a_i;
      pix_q[1] <= color_mode_q ? comp_b_i : 8'd0;
      pix_q[2] <= color_mode_q ? comp_c_i : 8'd0;
    end
  end

  // Horizontal step: one small multiplier pair per component lane
  logic [SUMW-1:0] prod_rem_q [LANES];
  logic [SUMW-1:0] colsum_q   [LANES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.horiz) begin
      for (int k = 0; k < LANES; k++) begin
        colsum_q[k]   <= col_part_q[k] + SUMW'({1'b0, pix_q[k]} * (SUMW+1)'(h_cur_q));
        prod_rem_q[k] <= SUMW'({1'b0, pix_q[k]} * (SUMW+1)'(h_rem_q));
      end
    end
  end

  // Line accumulator memory, one row of three components per output column
  logic [LANES*ACCW-1:0] mem [MAX_WIDTH];
  logic [LANES*ACCW-1:0] rd_q;
  logic [AW-1:0]         clr_cnt_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [LANES*ACCW-1:0] mem_wd;
  logic [ACCW-1:0]       wr_row_q [LANES];

  assign mem_we = cmd_i.clear || (cmd_i.finish && nv_q);
  assign mem_wa = cmd_i.clear ? clr_cnt_q : dst_col_q[AW-1:0];
  assign mem_wd = cmd_i.clear ? '0 : {wr_row_q[2], wr_row_q[1], wr_row_q[0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.horiz) rd_q <= mem[dst_col_q[AW-1:0]];
  end

  // Sweep the memory after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + AW'(1);
  end

  // Vertical step: one component lane per cycle
  logic [ACCW-1:0] rd_lane, acc;
  logic [ACCW:0]   acc_sum;
  logic [PW-1:0]   m_cur, m_rem;
  logic [7:0]      res_q [LANES];

  // Saturate the sum: anything past the accumulator range reads as full scale
  always_comb begin
    rd_lane = rd_q[cmd_i.lane*ACCW +: ACCW];
    m_cur   = PW'(colsum_q[cmd_i.lane]) * PW'(v_cur_q);
    m_rem   = PW'(colsum_q[cmd_i.lane]) * PW'(v_rem_q);
    acc_sum = (ACCW+1)'(rd_lane) + (ACCW+1)'(m_cur);
    acc     = acc_sum[ACCW] ? '1 : acc_sum[ACCW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vert) begin
      wr_row_q[cmd_i.lane] <= rc_q ? ACCW'(m_rem) : acc;
      res_q[cmd_i.lane]    <= acc[ACCW-1 -: 8];
    end
  end

  // Advance counters and spans at the end of the pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      dst_col_q <= '0;
      src_row_q <= '0;
      dst_row_q <= '0;
      x_span_q  <= WONE;
      y_span_q  <= WONE;
      for (int k = 0; k < LANES; k++) col_part_q[k] <= '0;
    end else if (cmd_i.finish) begin
      if (lc_q) begin
        src_col_q <= '0;
        dst_col_q <= '0;
        x_span_q  <= WONE;
        for (int k = 0; k < LANES; k++) col_part_q[k] <= '0;
        if (lr_q) begin
          src_row_q <= '0;
          dst_row_q <= '0;
          y_span_q  <= WONE;
        end else begin
          src_row_q <= src_row_q + ROW_W'(1);
          if (rc_q) begin
            if (dst_row_q < dh) dst_row_q <= dst_row_q + ROW_W'(1);
            y_span_q <= WONE - v_rem_q;
          end else begin
            y_span_q <= y_span_q - w_q;
          end
        end
      end else begin
        src_col_q <= src_col_q + CW'(1);
        if (nv_q) dst_col_q <= dst_col_q + CW'(1);
        if (cc_q) begin
          x_span_q <= WONE - h_rem_q;
          for (int k = 0; k < LANES; k++) col_part_q[k] <= prod_rem_q[k];
        end else begin
          x_span_q <= x_span_q - w_q;
          for (int k = 0; k < LANES; k++) col_part_q[k] <= colsum_q[k];
        end
      end
    end
  end

  // Output register
  logic out_valid_q;
  logic out_load;

  assign out_load = cmd_i.finish && nv_q && em_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_a_o     <= res_q[0];
      out_b_o     <= res_q[1];
      out_c_o     <= res_q[2];
      row_end_o   <= re_q;
      frame_end_o <= fe_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.clear_done = (clr_cnt_q == AW'(MAX_WIDTH - 1));
  assign status_o.need_vert  = nv_q;
  assign status_o.emit       = em_q;
  assign status_o.out_busy   = out_valid_q && out_stall_i;

endmodule

// File: hw/rtl/area_average_image_downscaler_core.sv
// Top level of the area-average image downscaler.
`timescale 1ns / 1ps

// Takes source pixels in raster order and emits area-weighted averages on a
// smaller grid, one output pixel when its last covering source pixel arrives.
// A pixel that closes no output column inside the destination width passes
// through accept, horizontal sum and counter update; one that closes such a
// column also has the line accumulator row read from memory, and its three
// components then pass one per cycle through a shared pair of multipliers
// before the counter update. When a result is due, a full output register
// holds the counter update until its transaction is taken. After reset the
// block clears every word of the accumulator memory before it takes its first
// pixel; configuration writes are taken at any time.
module area_average_image_downscaler_core import aaid_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        comp_a_i,
  input  logic [7:0]        comp_b_i,
  input  logic [7:0]        comp_c_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_a_o,
  output logic [7:0]        out_b_o,
  output logic [7:0]        out_c_o,
  output logic              row_end_o,
  output logic              frame_end_o
);

  aaid_cmd_t    cmd;
  aaid_status_t status;

  assign cfg_ready_o = 1'b1;

  aaid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aaid_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .comp_a_i    (comp_a_i),
    .comp_b_i    (comp_b_i),
    .comp_c_i    (comp_c_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// File: hw/rtl/aaid_checker.sv
// Port-level checker for the downscaler core and its bind.
`timescale 1ns / 1ps

module aaid_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_a_o,
  input logic       row_end_o,
  input logic       frame_end_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_a_o))
    else $error("stalled output transaction changed");

  // Frame end only on the last pixel of a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame_end without row_end");

  // One pixel at a time: stall right after an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  // A new result appears only while a pixel is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no pixel in work");

endmodule

bind area_average_image_downscaler_core aaid_checker u_aaid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_a_o     (out_a_o),
  .row_end_o   (row_end_o),
  .frame_end_o (frame_end_o)
);

// File: tb/area_average_image_downscaler_core_test.sv
// Self-checking testbench for the area-average image downscaler core.
`timescale 1ns / 1ps

module area_average_image_downscaler_core_test;
  import aaid_pkg::*;

  localparam int unsigned MAX_W   = 4096;
  localparam int unsigned WBITS   = 16;
  localparam longint unsigned ONE = 64'd1 << WBITS;
  localparam int unsigned SETTLE  = 16;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       row_end;
    logic       frame_end;
  } out_pixel_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        comp_a_i;
  logic [7:0]        comp_b_i;
  logic [7:0]        comp_c_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [7:0]        out_a_o;
  logic [7:0]        out_b_o;
  logic [7:0]        out_c_o;
  logic              row_end_o;
  logic              frame_end_o;

  // Shadow configuration, raw register contents
  logic [12:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic [16:0] weight_reg;
  logic        color_reg;

  // Shadow stream state
  longint unsigned line_sum[MAX_W*3];
  longint unsigned col_sum[3];
  longint unsigned x_left, y_left;
  int unsigned     src_col, src_row, dst_col, dst_row;

  out_pixel_t pending_pixels[$];
  int         fail_count;
  int         pixels_sent;
  bit         idle_enable;

  area_average_image_downscaler_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .comp_a_i    (comp_a_i),
    .comp_b_i    (comp_b_i),
    .comp_c_i    (comp_c_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned lo,
                                            longint unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Return shadow state to its reset values
  function automatic void reset_shadow();
    src_w_reg  = 13'd640;
    src_h_reg  = 13'd480;
    dst_w_reg  = 13'd320;
    dst_h_reg  = 13'd240;
    weight_reg = 17'd32768;
    color_reg  = 1'b1;
    foreach (line_sum[i]) line_sum[i] = 0;
    foreach (col_sum[i]) col_sum[i] = 0;
    x_left  = ONE;
    y_left  = ONE;
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
  endfunction

  // Advance the shadow downscaler by one source pixel, queue any output pixel
  function automatic void downscale_pixel(logic [7:0] pa, logic [7:0] pb, logic [7:0] pc);
    longint unsigned wt, sw, sh, dw, dh;
    longint unsigned h_cur, h_rem, v_cur, v_rem, acc, r;
    longint unsigned v[3], colsum[3], res[3];
    bit last_col, last_row, row_close, col_close, re, fe;
    int unsigned idx;
    out_pixel_t px;
    wt = clamp(64'(weight_reg), 1, ONE);
    sw = clamp(64'(src_w_reg), 1, MAX_W);
    sh = clamp(64'(src_h_reg), 1, MAX_HEIGHT);
    dw = clamp(64'(dst_w_reg), 1, MAX_W);
    dh = clamp(64'(dst_h_reg), 1, MAX_HEIGHT);
    last_col  = src_col + 1 >= sw;
    last_row  = src_row + 1 >= sh;
    row_close = (wt >= y_left) || last_row;
    v_cur     = wt < y_left ? wt : y_left;
    v_rem     = (wt > y_left && !last_row) ? wt - y_left : 0;
    col_close = (wt >= x_left) || last_col;
    h_cur     = wt < x_left ? wt : x_left;
    h_rem     = (wt > x_left && !last_col) ? wt - x_left : 0;
    v[0] = 64'(pa);
    v[1] = color_reg ? 64'(pb) : 64'd0;
    v[2] = color_reg ? 64'(pc) : 64'd0;

    if (!col_close) begin
      for (int k = 0; k < 3; k++) col_sum[k] += v[k] * wt;
      x_left -= wt;
    end else begin
      for (int k = 0; k < 3; k++) begin
        colsum[k]  = col_sum[k] + v[k] * h_cur;
        col_sum[k] = v[k] * h_rem;
      end
      x_left = ONE - h_rem;
      if (dst_col < dw) begin
        for (int k = 0; k < 3; k++) begin
          idx = dst_col * 3 + k;
          acc = line_sum[idx] + colsum[k] * v_cur;
          if (row_close) begin
            r = acc >> (2 * WBITS);
            res[k] = r > 255 ? 255 : r;
            line_sum[idx] = colsum[k] * v_rem;
          end else begin
            line_sum[idx] = acc;
          end
        end
        if (row_close && dst_row < dh) begin
          re = (dst_col + 1 == dw) || last_col;
          fe = re && ((dst_row + 1 == dh) || last_row);
          px.a = 8'(res[0]);
          px.b = 8'(res[1]);
          px.c = 8'(res[2]);
          px.row_end = re;
          px.frame_end = fe;
          pending_pixels.push_back(px);
        end
        dst_col++;
      end
    end

    if (last_col) begin
      src_col = 0;
      dst_col = 0;
      x_left  = ONE;
      foreach (col_sum[i]) col_sum[i] = 0;
      if (row_close) begin
        if (dst_row < dh) dst_row++;
        y_left = ONE - v_rem;
      end else begin
        y_left -= wt;
      end
      if (last_row) begin
        src_row = 0;
        dst_row = 0;
        y_left  = ONE;
      end else begin
        src_row++;
      end
    end else begin
      src_col++;
    end
  endfunction

  // Check each output transaction against the oldest expected pixel
  always @(posedge clk_i) begin
    out_pixel_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output pixel a=%0d b=%0d c=%0d", out_a_o, out_b_o, out_c_o);
        fail_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_a_o !== exp_px.a) begin
          $error("out_a expected %0d actual %0d", exp_px.a, out_a_o);
          fail_count++;
        end
        if (out_b_o !== exp_px.b) begin
          $error("out_b expected %0d actual %0d", exp_px.b, out_b_o);
          fail_count++;
        end
        if (out_c_o !== exp_px.c) begin
          $error("out_c expected %0d actual %0d", exp_px.c, out_c_o);
          fail_count++;
        end
        if (row_end_o !== exp_px.row_end) begin
          $error("row_end expected %0d actual %0d", exp_px.row_end, row_end_o);
          fail_count++;
        end
        if (frame_end_o !== exp_px.frame_end) begin
          $error("frame_end expected %0d actual %0d", exp_px.frame_end, frame_end_o);
          fail_count++;
        end
      end
    end
  end

  // Stall the output in random bursts, separated by free-running stretches, while idle_enable is set
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!idle_enable) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 20)) @(posedge clk_i);
        if (idle_enable) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 18)) @(posedge clk_i);
        end
      end
    end
  end

  // Write one configuration register and mirror it
  task automatic write_reg(cfg_reg_e index, logic [CFG_DW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      CFG_SRC_WIDTH:    src_w_reg  = value[12:0];
      CFG_SRC_HEIGHT:   src_h_reg  = value[12:0];
      CFG_DST_WIDTH:    dst_w_reg  = value[12:0];
      CFG_DST_HEIGHT:   dst_h_reg  = value[12:0];
      CFG_SCALE_WEIGHT: weight_reg = value;
      CFG_COLOR_MODE:   color_reg  = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic setup(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                       int unsigned wt, int unsigned color);
    write_reg(CFG_SRC_WIDTH, CFG_DW'(sw));
    write_reg(CFG_SRC_HEIGHT, CFG_DW'(sh));
    write_reg(CFG_DST_WIDTH, CFG_DW'(dw));
    write_reg(CFG_DST_HEIGHT, CFG_DW'(dh));
    write_reg(CFG_SCALE_WEIGHT, CFG_DW'(wt));
    write_reg(CFG_COLOR_MODE, CFG_DW'(color));
  endtask

  // Send one source pixel; valid stays high for a following pixel unless a random idle gap drops it
  task automatic send_pixel(logic [7:0] pa, logic [7:0] pb, logic [7:0] pc);
    in_valid_i <= 1'b1;
    comp_a_i   <= pa;
    comp_b_i   <= pb;
    comp_c_i   <= pc;
    do @(posedge clk_i); while (in_stall_o);
    downscale_pixel(pa, pb, pc);
    pixels_sent++;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Wait until every expected pixel has come out and the core has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_random_frame(int unsigned count);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
  endtask

  task automatic test_reset_values();
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    drain();
  endtask

  // Gray mode: b and c inputs are ignored and come out as zero
  task automatic test_gray_extremes();
    setup(4, 2, 2, 1, 32768, 0);
    for (int i = 0; i < 8; i++)
      send_pixel((i % 3 == 0) ? 8'd255 : 8'd0, 8'hAA, 8'h55);
    drain();
  endtask

  // Three components with a weight that does not divide evenly
  task automatic test_color_fraction();
    setup(3, 2, 2, 2, 43690, 1);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd128);
    send_pixel(8'd0, 8'd255, 8'd127);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd254, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    drain();
  endtask

  // Out-of-range register values are clamped
  task automatic test_register_clamp();
    setup(8191, 0, 8191, 0, 131071, 1);
    send_random_frame(6);
    drain();
    setup(0, 1, 0, 8191, 0, 1);
    send_random_frame(3);
    drain();
  endtask

  // Random frames, mostly well formed, sometimes odd weights or raw sizes
  task automatic test_random_frames(int unsigned target);
    int unsigned sw, sh, dw, dh, wt, nfr;
    while (pixels_sent < target) begin
      sw = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      sh = $urandom_range(1, 6);
      dw = $urandom_range(1, sw);
      dh = $urandom_range(1, sh);
      case ($urandom_range(0, 7))
        0, 1:    wt = $urandom_range(1, 65536);
        2:       wt = $urandom_range(0, 17'h1FFFF);
        3:       wt = 1;
        default: wt = (dw * 65536) / sw;
      endcase
      if ($urandom_range(0, 15) == 0) dw = $urandom_range(0, 8191);
      if ($urandom_range(0, 15) == 0) dh = $urandom_range(0, 8191);
      setup(sw, sh, dw, dh, wt, $urandom_range(0, 1));
      nfr = $urandom_range(1, 3);
      if (sw * sh * nfr > target - pixels_sent) nfr = 1;
      send_random_frame(sw * sh * nfr);
      drain();
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_SRC_WIDTH;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    comp_a_i    <= '0;
    comp_b_i    <= '0;
    comp_c_i    <= '0;
    fail_count  = 0;
    pixels_sent = 0;
    idle_enable = 1'b1;
    reset_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_gray_extremes();
    test_color_fraction();
    test_register_clamp();
    test_random_frames(1650);
    idle_enable = 1'b0;
    test_random_frames(1850);

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
